@@ hdl/tcpma_pkg.sv @@
// Package for the three-channel power meter average core.
// Holds field widths, scale constants, register indexes and shared types.
// No dependencies.
`default_nettype none

package tcpma_pkg;

	// Channel count and field widths
	localparam int NCH    = 3;
	localparam int RAW_W  = 16;
	localparam int FS_W   = 16;
	localparam int VOLT_W = 22;
	localparam int CURR_W = 25;
	// Current magnitude width before the sign is applied
	localparam int CMAG_W = 24;

	// mV per full-scale bus word; Q8 scaling is a right shift of 8
	localparam logic [13:0] VOLT_MUL   = 14'd9000;
	localparam logic [FS_W-1:0] FS_RST = 16'd1000;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FS_CH0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FS_CH1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FS_CH2 = 2'd2;

	// Stream widths, padded to whole bytes
	localparam int IN_DATA_W  = 96;
	localparam int OUT_BITS   = NCH * (2 * VOLT_W + 2 * CURR_W);
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [RAW_W-1:0]         raw_t;
	typedef logic [FS_W-1:0]          fs_t;
	typedef logic [VOLT_W-1:0]        volt_t;
	typedef logic signed [CURR_W-1:0] curr_t;

endpackage

`default_nettype wire

@@ hdl/three_channel_power_meter_average_core.sv @@
// Three-channel power meter: converts raw bus and sense words to Q8 mV / mA
// and keeps a per-channel boxcar average over WINDOW samples.
// The input transfer passes through registered stages s1 to s6 before output valid. Throughput:
// one transfer per cycle; each stage stalls only when the one after it is full and cannot advance.
// Reset: sample windows and running sums clear to zero, full scales to 1000.
// Depends on tcpma_pkg.
`default_nettype none

module three_channel_power_meter_average_core #(
	parameter int WINDOW = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration write port
	input  wire                                 cfg_we,
	input  wire [tcpma_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [tcpma_pkg::FS_W-1:0]           cfg_data,
	// input stream
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// s_tdata, low bit up: vbus_raw_ch0..2, vsense_raw_ch0..2 (16 bits each)
	input  wire [tcpma_pkg::IN_DATA_W-1:0]      s_tdata,
	// output stream
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// m_tdata, low bit up: voltage_ch0..2 (22), current_ch0..2 (25),
	// mean_voltage_ch0..2 (22), mean_current_ch0..2 (25), zero pad
	output logic [tcpma_pkg::OUT_DATA_W-1:0]    m_tdata
);

	import tcpma_pkg::*;

	// Sum widths and reciprocal constants for the divide by WINDOW
	localparam int LOG_W  = $clog2(WINDOW);
	localparam int VSUM_W = VOLT_W + LOG_W;
	localparam int IMAG_W = CMAG_W + LOG_W;
	localparam int ISUM_W = IMAG_W + 1;
	localparam int V_SH   = VSUM_W + LOG_W;
	localparam int I_SH   = IMAG_W + LOG_W;
	localparam int VPRD_W = 2 * VSUM_W + 1;
	localparam int IPRD_W = 2 * IMAG_W + 1;
	localparam logic [63:0] V_MUL64 =
		((64'd1 << V_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [63:0] I_MUL64 =
		((64'd1 << I_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [VSUM_W:0] V_RCP = V_MUL64[VSUM_W:0];
	localparam logic [IMAG_W:0] I_RCP = I_MUL64[IMAG_W:0];

	// Full-scale registers
	fs_t fs_q [NCH];

	// Stage valids and stage advance
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	// Payload registers
	raw_t                     vraw_s1 [NCH];
	raw_t                     sraw_s1 [NCH];
	volt_t                    v_s2 [NCH], v_s3 [NCH], v_s4 [NCH], v_s5 [NCH], v_s6 [NCH];
	curr_t                    i_s2 [NCH], i_s3 [NCH], i_s4 [NCH], i_s5 [NCH], i_s6 [NCH];
	logic [VSUM_W-1:0]        vsum_s3 [NCH];
	logic signed [ISUM_W-1:0] isum_s3 [NCH];
	logic [VSUM_W-1:0]        vmag_s4 [NCH];
	logic [IMAG_W-1:0]        imag_s4 [NCH];
	logic                     ineg_s4 [NCH], ineg_s5 [NCH];
	logic [VPRD_W-1:0]        vprd_s5 [NCH];
	logic [IPRD_W-1:0]        iprd_s5 [NCH];
	volt_t                    vmean_s6 [NCH];
	curr_t                    imean_s6 [NCH];

	// Sample windows as shift lines; the last tap is the oldest sample
	volt_t vwin_q [NCH][WINDOW];
	curr_t iwin_q [NCH][WINDOW];

	// Combinational conversion results
	volt_t v_c [NCH];
	curr_t i_c [NCH];
	logic [VSUM_W-1:0]        vsum_c [NCH];
	logic signed [ISUM_W-1:0] isum_c [NCH];
	logic signed [ISUM_W-1:0] ineg_c [NCH];

	// Each stage takes a new item when empty or when the next stage takes its own
	assign rdy_s6   = !vld_s6 || m_tready;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign m_tvalid = vld_s6;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) fs_q[c] <= FS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FS_CH0: fs_q[0] <= cfg_data;
				REG_FS_CH1: fs_q[1] <= cfg_data;
				REG_FS_CH2: fs_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	// Conversion to Q8 mV and mA, running-sum update and magnitude of the sum
	always_comb begin
		logic [29:0]       vprod;
		logic [16:0]       smag;
		logic [32:0]       sprod;
		logic [CURR_W-1:0] cq;
		for (int c = 0; c < NCH; c++) begin
			vprod  = 30'(vraw_s1[c]) * 30'(VOLT_MUL);
			v_c[c] = vprod[29:8];
			smag   = sraw_s1[c][RAW_W-1] ? (17'h10000 - {1'b0, sraw_s1[c]})
			                             : {1'b0, sraw_s1[c]};
			sprod  = 33'(smag) * 33'(fs_q[c]);
			cq     = {1'b0, sprod[30:7]};
			// negative sense word reads as positive current
			i_c[c] = sraw_s1[c][RAW_W-1] ? $signed(cq) : $signed(-cq);
			vsum_c[c] = vsum_s3[c] - VSUM_W'(vwin_q[c][WINDOW-1]) + VSUM_W'(v_s2[c]);
			isum_c[c] = isum_s3[c] - ISUM_W'(iwin_q[c][WINDOW-1]) + ISUM_W'(i_s2[c]);
			ineg_c[c] = -isum_s3[c];
		end
	end

	// Window state and running sums, updated as an item enters stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				vsum_s3[c] <= '0;
				isum_s3[c] <= '0;
				for (int k = 0; k < WINDOW; k++) begin
					vwin_q[c][k] <= '0;
					iwin_q[c][k] <= '0;
				end
			end
		end else if (rdy_s3 && vld_s2) begin
			for (int c = 0; c < NCH; c++) begin
				vsum_s3[c]   <= vsum_c[c];
				isum_s3[c]   <= isum_c[c];
				vwin_q[c][0] <= v_s2[c];
				iwin_q[c][0] <= i_s2[c];
				for (int k = 1; k < WINDOW; k++) begin
					vwin_q[c][k] <= vwin_q[c][k-1];
					iwin_q[c][k] <= iwin_q[c][k-1];
				end
			end
		end
	end

	// Payload pipeline
	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			// input register
			if (rdy_s1 && s_tvalid) begin
				vraw_s1[c] <= s_tdata[c*RAW_W +: RAW_W];
				sraw_s1[c] <= s_tdata[(NCH+c)*RAW_W +: RAW_W];
			end
			// converted samples
			if (rdy_s2 && vld_s1) begin
				v_s2[c] <= v_c[c];
				i_s2[c] <= i_c[c];
			end
			if (rdy_s3 && vld_s2) begin
				v_s3[c] <= v_s2[c];
				i_s3[c] <= i_s2[c];
			end
			// split the current sum into sign and magnitude
			if (rdy_s4 && vld_s3) begin
				v_s4[c]    <= v_s3[c];
				i_s4[c]    <= i_s3[c];
				vmag_s4[c] <= vsum_s3[c];
				ineg_s4[c] <= isum_s3[c][ISUM_W-1];
				imag_s4[c] <= isum_s3[c][ISUM_W-1] ? IMAG_W'(ineg_c[c])
				                                   : IMAG_W'(isum_s3[c]);
			end
			// reciprocal multiply for the divide by WINDOW
			if (rdy_s5 && vld_s4) begin
				v_s5[c]    <= v_s4[c];
				i_s5[c]    <= i_s4[c];
				ineg_s5[c] <= ineg_s4[c];
				vprd_s5[c] <= VPRD_W'(vmag_s4[c]) * VPRD_W'(V_RCP);
				iprd_s5[c] <= IPRD_W'(imag_s4[c]) * IPRD_W'(I_RCP);
			end
			// output register; the mean current keeps the sum's sign
			if (rdy_s6 && vld_s5) begin
				v_s6[c]     <= v_s5[c];
				i_s6[c]     <= i_s5[c];
				vmean_s6[c] <= vprd_s5[c][V_SH +: VOLT_W];
				imean_s6[c] <= ineg_s5[c]
					? $signed(-{1'b0, iprd_s5[c][I_SH +: CMAG_W]})
					: $signed({1'b0, iprd_s5[c][I_SH +: CMAG_W]});
			end
		end
	end

	// Output packing
	always_comb begin
		m_tdata = '0;
		for (int c = 0; c < NCH; c++) begin
			m_tdata[c*VOLT_W +: VOLT_W]                          = v_s6[c];
			m_tdata[NCH*VOLT_W + c*CURR_W +: CURR_W]             = i_s6[c];
			m_tdata[NCH*(VOLT_W+CURR_W) + c*VOLT_W +: VOLT_W]    = vmean_s6[c];
			m_tdata[NCH*(2*VOLT_W+CURR_W) + c*CURR_W +: CURR_W]  = imean_s6[c];
		end
	end

endmodule

`default_nettype wire
